@@ rtl/toc_pkg.sv @@
// Package for the text overlay character placer: command codes, item and
// result structs, and the configuration bundle. No dependencies.
package toc_pkg;

	typedef enum logic [2:0] {
		CMD_START_CURSOR = 3'd0,
		CMD_START_XY     = 3'd1,
		CMD_CHAR         = 3'd2,
		CMD_LOAD_WIDTH   = 3'd3,
		CMD_FLUSH        = 3'd4,
		CMD_HOME         = 3'd5
	} cmd_t;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_NUL     = 8'd0;

	typedef struct packed {
		logic [2:0]        command;
		logic [7:0]        char_code;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [5:0]        glyph_width;
	} cmd_item_t;

	typedef struct packed {
		logic              placed;
		logic [7:0]        char_out;
		logic signed [15:0] x_out;
		logic signed [15:0] y_out;
		logic [8:0]        line_count;
		logic [10:0]       queue_fill;
		logic              text_lost;
	} res_item_t;

	typedef struct packed {
		logic [12:0]       screen_width;
		logic [12:0]       screen_height;
		logic [6:0]        cell_width;
		logic [6:0]        cell_height;
		logic [6:0]        line_pitch;
		logic signed [15:0] scroll_offset;
		logic              cursor_print_enable;
		logic              xy_print_enable;
	} cfg_t;

endpackage

@@ rtl/toc_cfg.sv @@
// APB-style register file holding the placer's configuration.
// Depends on toc_pkg for the cfg_t bundle.
module toc_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output toc_pkg::cfg_t      cfg
);

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_CELL_WIDTH    = 3'd2,
		REG_CELL_HEIGHT   = 3'd3,
		REG_LINE_PITCH    = 3'd4,
		REG_SCROLL_OFFSET = 3'd5,
		REG_CURSOR_EN     = 3'd6,
		REG_XY_EN         = 3'd7
	} reg_idx_t;

	toc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width        <= 13'd640;
			cfg_q.screen_height       <= 13'd480;
			cfg_q.cell_width          <= 7'd8;
			cfg_q.cell_height         <= 7'd8;
			cfg_q.line_pitch          <= 7'd8;
			cfg_q.scroll_offset       <= 16'sd0;
			cfg_q.cursor_print_enable <= 1'b0;
			cfg_q.xy_print_enable     <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				REG_SCREEN_WIDTH:  cfg_q.screen_width        <= pwdata[12:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height       <= pwdata[12:0];
				REG_CELL_WIDTH:    cfg_q.cell_width          <= pwdata[6:0];
				REG_CELL_HEIGHT:   cfg_q.cell_height         <= pwdata[6:0];
				REG_LINE_PITCH:    cfg_q.line_pitch          <= pwdata[6:0];
				REG_SCROLL_OFFSET: cfg_q.scroll_offset       <= $signed(pwdata[15:0]);
				REG_CURSOR_EN:     cfg_q.cursor_print_enable <= pwdata[0];
				REG_XY_EN:         cfg_q.xy_print_enable     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SCREEN_WIDTH:  prdata = {19'd0, cfg_q.screen_width};
			REG_SCREEN_HEIGHT: prdata = {19'd0, cfg_q.screen_height};
			REG_CELL_WIDTH:    prdata = {25'd0, cfg_q.cell_width};
			REG_CELL_HEIGHT:   prdata = {25'd0, cfg_q.cell_height};
			REG_LINE_PITCH:    prdata = {25'd0, cfg_q.line_pitch};
			REG_SCROLL_OFFSET: prdata = {16'd0, cfg_q.scroll_offset};
			REG_CURSOR_EN:     prdata = {31'd0, cfg_q.cursor_print_enable};
			REG_XY_EN:         prdata = {31'd0, cfg_q.xy_print_enable};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/toc_width_mem.sv @@
// Glyph width table: 256 x 6 synchronous memory, one write and one
// registered read per cycle. No package dependency.
module toc_width_mem (
	input  logic       clk,
	input  logic       rd_en,
	input  logic       wr_en,
	input  logic [7:0] addr,
	input  logic [5:0] wdata,
	output logic [5:0] rdata
);

	logic [5:0] mem [256];
	logic [5:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/toc_place.sv @@
// Update stage of the placer: cursor, string and queue state, and the
// result of one command. Depends on toc_pkg for item, result and config types.
module toc_place #(
	parameter int QUEUE_DEPTH      = 1024,
	parameter int MAX_STRING_CHARS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  toc_pkg::cmd_item_t item,
	input  logic [5:0]         glyph_w,
	input  toc_pkg::cfg_t      cfg,
	output toc_pkg::res_item_t res
);

	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int SCW = $clog2(MAX_STRING_CHARS + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_CURSOR = 3'b010,
		ST_XY     = 3'b100
	} str_state_t;

	typedef logic signed [17:0] wide_t;

	function automatic logic signed [15:0] sat16(input wide_t v);
		if (v > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic wide_t sx(input logic signed [15:0] v);
		return {{2{v[15]}}, v};
	endfunction

	logic signed [15:0] cursor_x_q, cursor_y_q, work_x_q, work_y_q, margin_x_q;
	logic signed [15:0] cursor_x_d, cursor_y_d, work_x_d, work_y_d, margin_x_d;
	str_state_t         st_q, st_d;
	logic [SCW-1:0]     chars_q, chars_d;
	logic [8:0]         lines_q, lines_d;
	logic [QCW-1:0]     queued_q, queued_d;
	logic               lost_q, lost_d;

	logic signed [15:0] cx, cy, cx_new, cy_new, ysat, xstep, nly;
	wide_t              last_x, last_y;
	logic               use_cur, active, on_screen, room, wrap, is_nl, placed;
	logic [8:0]         lines_inc;

	assign use_cur   = (st_q == ST_CURSOR);
	assign cx        = use_cur ? cursor_x_q : work_x_q;
	assign cy        = use_cur ? cursor_y_q : work_y_q;
	assign last_x    = $signed({5'd0, cfg.screen_width}) - $signed({11'd0, cfg.cell_width});
	assign last_y    = $signed({5'd0, cfg.screen_height}) - $signed({11'd0, cfg.cell_height});
	assign ysat      = sat16(sx(cy) + sx(cfg.scroll_offset));
	assign on_screen = !ysat[15] && (sx(ysat) <= last_y);
	assign room      = (queued_q < QCW'(QUEUE_DEPTH));
	assign xstep     = sat16(sx(cx) + $signed({12'd0, glyph_w}));
	assign wrap      = (sx(xstep) > last_x);
	assign nly       = sat16(sx(cy) + $signed({11'd0, cfg.line_pitch}));
	assign lines_inc = (lines_q == 9'd511) ? lines_q : lines_q + 9'd1;
	assign is_nl     = (item.char_code == toc_pkg::CHAR_NEWLINE);
	assign active    = (st_q != ST_IDLE) && (item.char_code != toc_pkg::CHAR_NUL)
		&& (chars_q < SCW'(MAX_STRING_CHARS));

	// Position after a character: a newline or a right-edge overflow drops a
	// line and returns to the margin; otherwise x moves by the glyph width.
	always_comb begin
		if (is_nl || wrap) begin
			cx_new = margin_x_q;
			cy_new = nly;
		end else begin
			cx_new = xstep;
			cy_new = cy;
		end
	end

	always_comb begin
		cursor_x_d = cursor_x_q;
		cursor_y_d = cursor_y_q;
		work_x_d   = work_x_q;
		work_y_d   = work_y_q;
		margin_x_d = margin_x_q;
		st_d       = st_q;
		chars_d    = chars_q;
		lines_d    = lines_q;
		queued_d   = queued_q;
		lost_d     = lost_q;
		placed     = 1'b0;
		case (item.command)
			toc_pkg::CMD_START_CURSOR: begin
				st_d       = cfg.cursor_print_enable ? ST_CURSOR : ST_IDLE;
				margin_x_d = 16'sd0;
				chars_d    = '0;
				lines_d    = '0;
			end
			toc_pkg::CMD_START_XY: begin
				if (cfg.xy_print_enable) begin
					st_d       = ST_XY;
					work_x_d   = item.pos_x;
					work_y_d   = item.pos_y;
					margin_x_d = item.pos_x;
				end else begin
					st_d = ST_IDLE;
				end
				chars_d = '0;
				lines_d = '0;
			end
			toc_pkg::CMD_CHAR: begin
				if (active) begin
					chars_d = chars_q + SCW'(1);
					if (is_nl || wrap) begin
						lines_d = lines_inc;
					end
					if (!is_nl) begin
						if (on_screen && room) begin
							queued_d = queued_q + QCW'(1);
							placed   = 1'b1;
						end else begin
							lost_d = 1'b1;
						end
					end
					if (use_cur) begin
						cursor_x_d = cx_new;
						cursor_y_d = cy_new;
					end else begin
						work_x_d = cx_new;
						work_y_d = cy_new;
					end
				end
			end
			toc_pkg::CMD_FLUSH: begin
				queued_d = '0;
				lost_d   = 1'b0;
			end
			toc_pkg::CMD_HOME: begin
				cursor_x_d = 16'sd0;
				cursor_y_d = 16'sd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= 16'sd0;
			cursor_y_q <= 16'sd0;
			work_x_q   <= 16'sd0;
			work_y_q   <= 16'sd0;
			margin_x_q <= 16'sd0;
			st_q       <= ST_IDLE;
			chars_q    <= '0;
			lines_q    <= '0;
			queued_q   <= '0;
			lost_q     <= 1'b0;
		end else if (fire) begin
			cursor_x_q <= cursor_x_d;
			cursor_y_q <= cursor_y_d;
			work_x_q   <= work_x_d;
			work_y_q   <= work_y_d;
			margin_x_q <= margin_x_d;
			st_q       <= st_d;
			chars_q    <= chars_d;
			lines_q    <= lines_d;
			queued_q   <= queued_d;
			lost_q     <= lost_d;
		end
	end

	always_comb begin
		res.placed     = placed;
		res.char_out   = placed ? item.char_code : 8'd0;
		res.x_out      = placed ? cx : 16'sd0;
		res.y_out      = placed ? ysat : 16'sd0;
		res.line_count = lines_d;
		res.queue_fill = 11'(queued_d);
		res.text_lost  = lost_d;
	end

endmodule

@@ rtl/text_overlay_char_placer_top.sv @@
// Text overlay character placer, top level. An accepted item waits in the
// width-read stage for its glyph width, then its result item is registered
// in the output register. Throughput: one item per cycle while the output is
// not stalled, set by the single width table read port and the cursor add and
// compare in the update stage. Reset (arst_n, asynchronous) clears all control
// and cursor state and loads the register defaults; the width table is not
// cleared and holds nothing meaningful until loaded.
module text_overlay_char_placer_top #(
	parameter int QUEUE_DEPTH      = 1024,
	parameter int MAX_STRING_CHARS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  toc_pkg::cmd_item_t cmd_item,
	output logic               res_valid,
	input  logic               res_stall,
	output toc_pkg::res_item_t res_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	toc_pkg::cfg_t      cfg;
	toc_pkg::cmd_item_t item_s1;
	toc_pkg::res_item_t res_d;
	toc_pkg::res_item_t res_q;
	logic               valid_s1;
	logic               res_valid_q;
	logic               accept;
	logic               advance;
	logic [5:0]         glyph_w_s1;

	// The item in the read stage moves on whenever the output register is
	// empty or is being emptied this cycle. The input only waits when the
	// read stage is full and cannot move, so a new item enters every cycle
	// under a free-flowing output.
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign accept    = cmd_valid && !cmd_stall;

	toc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The width table is read and written at the acceptance edge. Loads and
	// reads therefore take effect in item order, and a character right after
	// a width load of the same code already sees the new width.
	toc_width_mem u_mem (
		.clk   (clk),
		.rd_en (accept),
		.wr_en (accept && (cmd_item.command == toc_pkg::CMD_LOAD_WIDTH)),
		.addr  (cmd_item.char_code),
		.wdata (cmd_item.glyph_width),
		.rdata (glyph_w_s1)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// State update stage: all cursor, string and queue state is read and
	// written back here, once per item, so each item sees what the one
	// before it left.
	toc_place #(
		.QUEUE_DEPTH      (QUEUE_DEPTH),
		.MAX_STRING_CHARS (MAX_STRING_CHARS)
	) u_place (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.item    (item_s1),
		.glyph_w (glyph_w_s1),
		.cfg     (cfg),
		.res     (res_d)
	);

	// Output register: holds a result item until it is taken.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

@@ rtl/toc_checker.sv @@
// Port-level checks for the text overlay character placer, bound to the top.
// Depends on toc_pkg for the item and result types.
module toc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_stall,
	input logic               res_valid,
	input logic               res_stall,
	input toc_pkg::res_item_t res_item
);

	// The input only waits behind a result that is itself held.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (res_valid && res_stall))
		else $error("input stalled while the output was free");

	// A held result stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res_item)))
		else $error("held result changed or vanished");

	// An edge seen in reset clears the output, so nothing is offered at the
	// edge that follows it.
	assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result offered right after reset");

	// A placed character was counted in the queue, and an unplaced result
	// carries no character or position.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.placed ? (res_item.queue_fill != 11'd0)
			: (res_item.char_out == 8'd0 && res_item.x_out == 16'sd0
			&& res_item.y_out == 16'sd0)))
		else $error("result fields inconsistent with placed flag");

endmodule

bind text_overlay_char_placer_top toc_checker u_toc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

@@ tb/text_overlay_char_placer_top_tb.sv @@
// Self-checking testbench for text_overlay_char_placer_top: drives command items
// and APB register writes, predicts every result item and checks it field by field.
// Depends on toc_pkg and the top level only.
module text_overlay_char_placer_top_tb;

	localparam int QUEUE_DEPTH      = 1024;
	localparam int MAX_STRING_CHARS = 256;
	localparam int CYCLE_LIMIT      = 200000;

	// Command codes 6 and 7 have no meaning and must be ignored.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	localparam int REG_SCREEN_WIDTH  = 0;
	localparam int REG_SCREEN_HEIGHT = 1;
	localparam int REG_CELL_WIDTH    = 2;
	localparam int REG_CELL_HEIGHT   = 3;
	localparam int REG_LINE_PITCH    = 4;
	localparam int REG_SCROLL_OFFSET = 5;
	localparam int REG_CURSOR_ENABLE = 6;
	localparam int REG_XY_ENABLE     = 7;

	typedef enum logic [2:0] {
		TXT_IDLE   = 3'b001,
		TXT_CURSOR = 3'b010,
		TXT_XY     = 3'b100
	} text_mode_t;

	logic                clk;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_stall;
	toc_pkg::cmd_item_t  cmd_item;
	logic                res_valid;
	logic                res_stall;
	toc_pkg::res_item_t  res_item;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [4:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// Shadow of the block: registers, width table, cursors and string state.
	toc_pkg::cfg_t       cfg_shadow;
	logic [5:0]          glyph_widths [256];
	logic                width_loaded [256];
	logic [7:0]          loaded_codes [$];
	int                  cur_x, cur_y, str_x, str_y, margin_x;
	text_mode_t          text_mode;
	int                  str_chars, str_lines, queue_count;
	logic                lost_sticky;

	// Predicted placement records, oldest first.
	toc_pkg::res_item_t  placement_log [$];

	int                  items_sent, drops_seen;
	int                  err_count    = 0;
	int                  results_seen = 0;
	int                  chars_placed = 0;
	int                  cycle_count;
	// While set, neither side idles: a stretch at full rate.
	logic                steady;

	text_overlay_char_placer_top #(
		.QUEUE_DEPTH      (QUEUE_DEPTH),
		.MAX_STRING_CHARS (MAX_STRING_CHARS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// Placement predictor
	// ------------------------------------------------------------------

	function automatic int sat16(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Move down one line and back to the left margin of the open string.
	function automatic void line_feed(inout int x, inout int y);
		y = sat16(y + int'(cfg_shadow.line_pitch));
		x = margin_x;
		if (str_lines < 511) str_lines++;
	endfunction

	function automatic void overlay_reset();
		cfg_shadow.screen_width        = 13'd640;
		cfg_shadow.screen_height       = 13'd480;
		cfg_shadow.cell_width          = 7'd8;
		cfg_shadow.cell_height         = 7'd8;
		cfg_shadow.line_pitch          = 7'd8;
		cfg_shadow.scroll_offset       = 16'sd0;
		cfg_shadow.cursor_print_enable = 1'b0;
		cfg_shadow.xy_print_enable     = 1'b1;
		foreach (width_loaded[i]) begin
			width_loaded[i] = 1'b0;
			glyph_widths[i] = '0;
		end
		loaded_codes.delete();
		cur_x       = 0;
		cur_y       = 0;
		str_x       = 0;
		str_y       = 0;
		margin_x    = 0;
		text_mode   = TXT_IDLE;
		str_chars   = 0;
		str_lines   = 0;
		queue_count = 0;
		lost_sticky = 1'b0;
	endfunction

	// Applies one command to the shadow state and returns the status item
	// the block must report for it.
	function automatic toc_pkg::res_item_t advance_overlay(toc_pkg::cmd_item_t it);
		toc_pkg::res_item_t r;
		int x, y, y_shown, last_x, last_y;
		r = '0;
		case (it.command)
		toc_pkg::CMD_START_CURSOR: begin
			text_mode = cfg_shadow.cursor_print_enable ? TXT_CURSOR : TXT_IDLE;
			margin_x  = 0;
			str_chars = 0;
			str_lines = 0;
		end
		toc_pkg::CMD_START_XY: begin
			if (cfg_shadow.xy_print_enable) begin
				text_mode = TXT_XY;
				str_x     = int'($signed(it.pos_x));
				str_y     = int'($signed(it.pos_y));
				margin_x  = str_x;
			end else begin
				text_mode = TXT_IDLE;
			end
			str_chars = 0;
			str_lines = 0;
		end
		toc_pkg::CMD_CHAR: begin
			if (text_mode != TXT_IDLE && it.char_code != toc_pkg::CHAR_NUL &&
					str_chars < MAX_STRING_CHARS) begin
				x = (text_mode == TXT_CURSOR) ? cur_x : str_x;
				y = (text_mode == TXT_CURSOR) ? cur_y : str_y;
				str_chars++;
				if (it.char_code == toc_pkg::CHAR_NEWLINE) begin
					line_feed(x, y);
				end else begin
					y_shown = sat16(y + int'($signed(cfg_shadow.scroll_offset)));
					last_y  = int'(cfg_shadow.screen_height) - int'(cfg_shadow.cell_height);
					last_x  = int'(cfg_shadow.screen_width) - int'(cfg_shadow.cell_width);
					// A character off screen or with the queue full is lost,
					// but the cursor moves on all the same.
					if (y_shown >= 0 && y_shown <= last_y && queue_count < QUEUE_DEPTH) begin
						queue_count++;
						r.placed   = 1'b1;
						r.char_out = it.char_code;
						r.x_out    = x[15:0];
						r.y_out    = y_shown[15:0];
					end else begin
						lost_sticky = 1'b1;
						drops_seen++;
					end
					x = sat16(x + int'(glyph_widths[it.char_code]));
					if (x > last_x) line_feed(x, y);
				end
				if (text_mode == TXT_CURSOR) begin
					cur_x = x;
					cur_y = y;
				end else begin
					str_x = x;
					str_y = y;
				end
			end
		end
		toc_pkg::CMD_LOAD_WIDTH: begin
			glyph_widths[it.char_code] = it.glyph_width;
			if (!width_loaded[it.char_code]) begin
				width_loaded[it.char_code] = 1'b1;
				loaded_codes.push_back(it.char_code);
			end
		end
		toc_pkg::CMD_FLUSH: begin
			queue_count = 0;
			lost_sticky = 1'b0;
		end
		toc_pkg::CMD_HOME: begin
			cur_x = 0;
			cur_y = 0;
		end
		default: ;
		endcase
		r.line_count = 9'(str_lines);
		r.queue_fill = 11'(queue_count);
		r.text_lost  = lost_sticky;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic toc_pkg::cmd_item_t make_cmd(logic [2:0] op, logic [7:0] code, int x,
			int y, logic [5:0] w);
		toc_pkg::cmd_item_t it;
		it.command     = op;
		it.char_code   = code;
		it.pos_x       = x[15:0];
		it.pos_y       = y[15:0];
		it.glyph_width = w;
		return it;
	endfunction

	// Character code for a command 2. Only codes whose width has been loaded
	// are used, apart from newline and NUL, which never use a glyph width.
	function automatic logic [7:0] pick_glyph(int special_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < special_pct) begin
			return $urandom_range(0, 1) ? toc_pkg::CHAR_NEWLINE : toc_pkg::CHAR_NUL;
		end
		if (loaded_codes.size() == 0) return toc_pkg::CHAR_NEWLINE;
		return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
	endfunction

	// A coordinate in or just around the visible range.
	function automatic logic [15:0] coord_near(int span);
		int v;
		v = int'($urandom_range(0, span + 16)) - 8;
		return v[15:0];
	endfunction

	// Mostly characters of open strings, with string starts, width loads, flushes,
	// homes and the spare codes 6 and 7 mixed in; all other fields carry random bits.
	function automatic toc_pkg::cmd_item_t random_cmd();
		toc_pkg::cmd_item_t it;
		int r;
		it.command     = toc_pkg::CMD_CHAR;
		it.char_code   = 8'($urandom);
		it.pos_x       = 16'($urandom);
		it.pos_y       = 16'($urandom);
		it.glyph_width = 6'($urandom);
		r = $urandom_range(0, 99);
		if (r < 58) begin
			it.char_code = pick_glyph(9);
		end else if (r < 68) begin
			it.command = toc_pkg::CMD_START_XY;
			it.pos_x   = coord_near(int'(cfg_shadow.screen_width));
			it.pos_y   = coord_near(int'(cfg_shadow.screen_height));
		end else if (r < 72) begin
			it.command = toc_pkg::CMD_START_XY;
		end else if (r < 79) begin
			it.command = toc_pkg::CMD_START_CURSOR;
		end else if (r < 89) begin
			it.command = toc_pkg::CMD_LOAD_WIDTH;
		end else if (r < 93) begin
			it.command = toc_pkg::CMD_FLUSH;
		end else if (r < 98) begin
			it.command = toc_pkg::CMD_HOME;
		end else begin
			it.command = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
		end
		return it;
	endfunction

	function automatic toc_pkg::cfg_t make_cfg(int sw, int sh, int cw, int chh, int pitch,
			int scroll, logic cur_en, logic xy_en);
		toc_pkg::cfg_t c;
		c.screen_width        = 13'(sw);
		c.screen_height       = 13'(sh);
		c.cell_width          = 7'(cw);
		c.cell_height         = 7'(chh);
		c.line_pitch          = 7'(pitch);
		c.scroll_offset       = 16'(scroll);
		c.cursor_print_enable = cur_en;
		c.xy_print_enable     = xy_en;
		return c;
	endfunction

	// Offers one item, possibly after random idle cycles, and waits until it
	// is taken. Valid stays high afterwards so back-to-back items need no
	// second assignment in the same step.
	task automatic send_cmd(input toc_pkg::cmd_item_t it);
		while (!steady && $urandom_range(0, 99) < 34) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		placement_log.push_back(advance_overlay(it));
		items_sent++;
	endtask

	// Stops offering items and waits until every predicted result is in.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (placement_log.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// One APB write; the bus is left selected so that writes can follow
	// back to back, and the caller returns it to idle.
	task automatic reg_write(input int idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
		REG_SCREEN_WIDTH:  cfg_shadow.screen_width        = value[12:0];
		REG_SCREEN_HEIGHT: cfg_shadow.screen_height       = value[12:0];
		REG_CELL_WIDTH:    cfg_shadow.cell_width          = value[6:0];
		REG_CELL_HEIGHT:   cfg_shadow.cell_height         = value[6:0];
		REG_LINE_PITCH:    cfg_shadow.line_pitch          = value[6:0];
		REG_SCROLL_OFFSET: cfg_shadow.scroll_offset       = value[15:0];
		REG_CURSOR_ENABLE: cfg_shadow.cursor_print_enable = value[0];
		REG_XY_ENABLE:     cfg_shadow.xy_print_enable     = value[0];
		default: ;
		endcase
	endtask

	task automatic apply_config(input toc_pkg::cfg_t c);
		wait_idle();
		reg_write(REG_SCREEN_WIDTH, 32'(c.screen_width));
		reg_write(REG_SCREEN_HEIGHT, 32'(c.screen_height));
		reg_write(REG_CELL_WIDTH, 32'(c.cell_width));
		reg_write(REG_CELL_HEIGHT, 32'(c.cell_height));
		reg_write(REG_LINE_PITCH, 32'(c.line_pitch));
		reg_write(REG_SCROLL_OFFSET, 32'(c.scroll_offset));
		reg_write(REG_CURSOR_ENABLE, 32'(c.cursor_print_enable));
		reg_write(REG_XY_ENABLE, 32'(c.xy_print_enable));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall and the field-by-field check
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		res_stall <= !steady && ($urandom_range(0, 99) < 34);
	end

	function automatic void compare_result(toc_pkg::res_item_t want, toc_pkg::res_item_t got);
		results_seen++;
		if (want.placed) chars_placed++;
		if (got.placed !== want.placed) begin
			$error("placed: expected %0d, got %0d", want.placed, got.placed);
			err_count++;
		end
		if (got.char_out !== want.char_out) begin
			$error("char_out: expected %0d, got %0d", want.char_out, got.char_out);
			err_count++;
		end
		if (got.x_out !== want.x_out) begin
			$error("x_out: expected %0d, got %0d", want.x_out, got.x_out);
			err_count++;
		end
		if (got.y_out !== want.y_out) begin
			$error("y_out: expected %0d, got %0d", want.y_out, got.y_out);
			err_count++;
		end
		if (got.line_count !== want.line_count) begin
			$error("line_count: expected %0d, got %0d", want.line_count, got.line_count);
			err_count++;
		end
		if (got.queue_fill !== want.queue_fill) begin
			$error("queue_fill: expected %0d, got %0d", want.queue_fill, got.queue_fill);
			err_count++;
		end
		if (got.text_lost !== want.text_lost) begin
			$error("text_lost: expected %0d, got %0d", want.text_lost, got.text_lost);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (placement_log.size() == 0) begin
				$error("result item arrived with nothing pending");
				err_count++;
			end else begin
				compare_result(placement_log.pop_front(), res_item);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: 640x480 screen, 8 pixel cells, cursor strings disabled.
	task automatic test_directed_cases();
		send_cmd(make_cmd(toc_pkg::CMD_LOAD_WIDTH, 8'hFF, 0, 0, 6'd63));
		send_cmd(make_cmd(toc_pkg::CMD_LOAD_WIDTH, 8'h41, 0, 0, 6'd0));
		// Codes at and above 128 index the table as unsigned values.
		send_cmd(make_cmd(toc_pkg::CMD_LOAD_WIDTH, 8'h80, 0, 0, 6'd7));
		send_cmd(make_cmd(toc_pkg::CMD_LOAD_WIDTH, 8'h01, 0, 0, 6'd1));
		// A character with no string open does nothing.
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, 8'h41, 0, 0, 6'd0));
		// Cursor strings are disabled, so this start leaves no string open.
		send_cmd(make_cmd(toc_pkg::CMD_START_CURSOR, 8'h00, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, 8'h41, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_START_XY, 8'h00, 10, 20, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, 8'h80, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, toc_pkg::CHAR_NUL, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, 8'hFF, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, toc_pkg::CHAR_NEWLINE, 0, 0, 6'd0));
		send_cmd(make_cmd(CMD_SPARE_6, 8'hFF, -1, -1, 6'd63));
		send_cmd(make_cmd(CMD_SPARE_7, 8'h55, 12345, -12345, 6'd21));
		// Far off screen at the top: clipped, and the lost flag sticks.
		send_cmd(make_cmd(toc_pkg::CMD_START_XY, 8'h00, -32768, -32768, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, 8'h80, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_FLUSH, 8'h00, 0, 0, 6'd0));
		// At the positive limit both coordinates saturate.
		send_cmd(make_cmd(toc_pkg::CMD_START_XY, 8'h00, 32767, 32767, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, 8'hFF, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, toc_pkg::CHAR_NEWLINE, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_HOME, 8'h00, 0, 0, 6'd0));
		// Last displayable row, then a right-edge wrap that falls off the bottom.
		send_cmd(make_cmd(toc_pkg::CMD_START_XY, 8'h00, 600, 472, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, 8'hFF, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_CHAR, 8'h41, 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_FLUSH, 8'h00, 0, 0, 6'd0));
	endtask

	// Random traffic under several register settings, the extremes among them.
	task automatic test_register_sweep();
		toc_pkg::cfg_t plans [8];
		plans[0] = make_cfg(1, 1, 1, 1, 1, 0, 1'b1, 1'b1);
		plans[1] = make_cfg(4096, 4096, 64, 64, 64, 32767, 1'b1, 1'b0);
		plans[2] = make_cfg(640, 480, 8, 8, 8, -32768, 1'b0, 1'b1);
		plans[3] = make_cfg(100, 100, 1, 64, 7, -20, 1'b1, 1'b1);
		for (int i = 4; i < 7; i++) begin
			plans[i] = make_cfg($urandom_range(1, 4096), $urandom_range(1, 4096),
				$urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
				int'($urandom_range(0, 200)) - 100, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end
		plans[7] = make_cfg(320, 240, 6, 10, 12, 5, 1'b1, 1'b1);
		foreach (plans[p]) begin
			apply_config(plans[p]);
			repeat (10) send_cmd(random_cmd());
		end
	endtask

	// Long well-formed strings without a flush: the per-string limit cuts
	// the first one, and the queue fills and overflows in the last one.
	task automatic test_queue_overflow();
		int lens [5];
		lens = '{270, 200, 200, 200, 240};
		apply_config(make_cfg(4096, 4096, 1, 1, 1, 0, 1'b1, 1'b1));
		send_cmd(make_cmd(toc_pkg::CMD_LOAD_WIDTH, 8'($urandom), 0, 0, 6'($urandom)));
		send_cmd(make_cmd(toc_pkg::CMD_FLUSH, 8'h00, 0, 0, 6'd0));
		foreach (lens[s]) begin
			steady = (s == 1 || s == 2);
			if (s % 2 == 0) begin
				send_cmd(make_cmd(toc_pkg::CMD_START_XY, 8'($urandom),
					$urandom_range(0, 2000), $urandom_range(0, 1000), 6'($urandom)));
			end else begin
				send_cmd(make_cmd(toc_pkg::CMD_HOME, 8'($urandom), 0, 0, 6'($urandom)));
				send_cmd(make_cmd(toc_pkg::CMD_START_CURSOR, 8'($urandom), 0, 0,
					6'($urandom)));
			end
			repeat (lens[s]) send_cmd(make_cmd(toc_pkg::CMD_CHAR, pick_glyph(2), 0, 0, 6'd0));
		end
		steady = 1'b0;
		repeat (20) send_cmd(make_cmd(toc_pkg::CMD_CHAR, pick_glyph(2), 0, 0, 6'd0));
		send_cmd(make_cmd(toc_pkg::CMD_FLUSH, 8'h00, 0, 0, 6'd0));
		repeat (10) send_cmd(make_cmd(toc_pkg::CMD_CHAR, pick_glyph(5), 0, 0, 6'd0));
	endtask

	// ------------------------------------------------------------------
	// Sequence and end of run
	// ------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd_item     = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		steady       = 1'b0;
		items_sent   = 0;
		drops_seen   = 0;
		overlay_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_register_sweep();
		test_queue_overflow();

		wait_idle();
		repeat (6) @(posedge clk);
		$display("Sent %0d command items under 10 register settings; checked %0d results.",
			items_sent, results_seen);
		$display("Characters placed: %0d, clipped or dropped for a full queue: %0d.",
			chars_placed, drops_seen);
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ text_overlay_char_placer_top.f @@
rtl/toc_pkg.sv
rtl/toc_cfg.sv
rtl/toc_width_mem.sv
rtl/toc_place.sv
rtl/text_overlay_char_placer_top.sv
rtl/toc_checker.sv
tb/text_overlay_char_placer_top_tb.sv
